/* hw/rtl/sktab_pkg.sv */
// ----------------------------------------------------------------------------
// sktab_pkg
// Types and codes shared by the sorted key table engine.
// ----------------------------------------------------------------------------
package sktab_pkg;

	localparam logic [2:0] CMD_PROBE   = 3'd0;
	localparam logic [2:0] CMD_READ    = 3'd1;
	localparam logic [2:0] CMD_INSERT  = 3'd2;
	localparam logic [2:0] CMD_SHIFT   = 3'd3;
	localparam logic [2:0] CMD_DELETE  = 3'd4;
	localparam logic [2:0] CMD_EXTRACT = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SMALL = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [31:0]        key_a;
		logic [31:0]        key_b;
		logic [5:0]         cursor_in;
		logic [31:0]        child_in;
		logic signed [31:0] delta;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [5:0]  cursor_out;
		logic        has_entry;
		logic [31:0] key_out;
		logic [31:0] child_out;
		logic [5:0]  entry_count;
		logic        last;
	} out_word_t;

	// per-cell command for one pass step
	typedef struct packed {
		logic        shift_up;   // take left neighbor (insert)
		logic        shift_dn;   // take right neighbor (removal)
		logic        load;       // load new entry
		logic        sub;        // key minus delta
	} cell_ctl_t;

endpackage

/* hw/rtl/sktab_cell.sv */
// ----------------------------------------------------------------------------
// sktab_cell
// One table slot: holds a key and child; loads a new entry, takes a neighbor's, or subtracts delta.
// ----------------------------------------------------------------------------
module sktab_cell #(
	parameter int CHILD_BITS = 32
) (
	input  logic                     clk,
	input  sktab_pkg::cell_ctl_t     ctl,
	input  logic [31:0]              left_key,
	input  logic [CHILD_BITS-1:0]    left_child,
	input  logic [31:0]              right_key,
	input  logic [CHILD_BITS-1:0]    right_child,
	input  logic [31:0]              new_key,
	input  logic [CHILD_BITS-1:0]    new_child,
	input  logic [31:0]              delta,
	output logic [31:0]              key,
	output logic [CHILD_BITS-1:0]    child
);
	import sktab_pkg::*;

	logic [31:0]           key_q;
	logic [CHILD_BITS-1:0] child_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q   <= new_key;
			child_q <= new_child;
		end else if (ctl.shift_up) begin
			key_q   <= left_key;
			child_q <= left_child;
		end else if (ctl.shift_dn) begin
			key_q   <= right_key;
			child_q <= right_child;
		end else if (ctl.sub) begin
			key_q   <= key_q - delta;
		end
	end

	assign key   = key_q;
	assign child = child_q;

endmodule

/* hw/rtl/sorted_key_table_engine_top.sv */
// ----------------------------------------------------------------------------
// sorted_key_table_engine_top
// Sorted key table held in a row of cells; a scan cursor walks the row.
// ----------------------------------------------------------------------------
// The scan cursor inspects one cell per cycle, removals compact one slot per cycle, and
// extract emits one word per cycle while the output accepts words.
// Throughput: one command at a time; the next is taken with the last word of the previous one.
// Reset clears the entry count and control; cell contents are left unknown.
module sorted_key_table_engine_top #(
	parameter int DEPTH      = 32,
	parameter int CHILD_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sktab_pkg::in_word_t   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sktab_pkg::out_word_t  out_data
);
	import sktab_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_MOVE = 3'd2;
	localparam logic [2:0] S_EMIT = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]            state_q;
	in_word_t              cmd_q;
	logic [CW-1:0]         fill_q;
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         lo_q;
	logic [CW-1:0]         hi_q;
	logic [CW-1:0]         l_q;
	logic [CW-1:0]         r_q;
	logic                  have_l_q;
	logic                  have_r_q;
	logic                  have_lo_q;
	logic                  have_hi_q;
	logic [CW-1:0]         mv_q;
	out_word_t             res_q;
	logic                  res_v_q;

	logic [31:0]           cell_key [DEPTH];
	logic [CHILD_BITS-1:0] cell_child [DEPTH];
	cell_ctl_t             ctl [DEPTH];

	logic [31:0]           cur_key;
	logic                  in_fill;
	logic [31:0]           cmd_child;
	logic                  out_fire;
	logic                  emit_now;
	out_word_t             res_init;

	assign in_fill   = idx_q < fill_q;
	assign cur_key   = cell_key[idx_q[IW-1:0]];
	assign cmd_child = cmd_q.child_in;

	function automatic logic [31:0] child32(input logic [CHILD_BITS-1:0] c);
		logic [63:0] w;
		w = 64'(c);
		return w[31:0];
	endfunction

	assign out_fire = (!res_v_q || out_ready) &&
		((state_q == S_OUT) || (state_q == S_EMIT && hi_q > lo_q));

	// extract emits slot lo then compacts it away the same cycle
	assign emit_now = out_fire && (state_q == S_EMIT);

	// insert shifts the cells above the insert position up in one step via neighbor links
	logic          ins_go;
	logic [CW-1:0] ins_pos;
	logic          sub_go;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic [31:0]           lk, rk;
			logic [CHILD_BITS-1:0] lc, rc;
			if (g == 0) begin : g_l0
				assign lk = cell_key[0];
				assign lc = cell_child[0];
			end else begin : g_ln
				assign lk = cell_key[g-1];
				assign lc = cell_child[g-1];
			end
			if (g == DEPTH - 1) begin : g_rn
				assign rk = cell_key[g];
				assign rc = cell_child[g];
			end else begin : g_r
				assign rk = cell_key[g+1];
				assign rc = cell_child[g+1];
			end
			always_comb begin
				ctl[g].load     = ins_go && (ins_pos == CW'(g));
				ctl[g].shift_up = ins_go && (CW'(g) > ins_pos) && (CW'(g) <= fill_q);
				ctl[g].shift_dn = ((state_q == S_MOVE) || emit_now) && (CW'(g) >= lo_q);
				ctl[g].sub      = sub_go && (idx_q == CW'(g));
			end
			sktab_cell #(.CHILD_BITS(CHILD_BITS)) u_cell (
				.clk        (clk),
				.ctl        (ctl[g]),
				.left_key   (lk),
				.left_child (lc),
				.right_key  (rk),
				.right_child(rc),
				.new_key    (cmd_q.key_a),
				.new_child  (CHILD_BITS'(cmd_child)),
				.delta      (cmd_q.delta),
				.key        (cell_key[g]),
				.child      (cell_child[g])
			);
		end
	endgenerate

	// result word prepared at accept
	always_comb begin
		res_init      = '0;
		res_init.last = 1'b1;
		if (in_data.cmd == CMD_PROBE) begin
			res_init.cursor_out = in_data.cursor_in;
		end else if (in_data.cmd == CMD_READ) begin
			if (7'(in_data.cursor_in) >= 7'(fill_q)) begin
				res_init.status = ST_RANGE;
			end else begin
				res_init.has_entry = 1'b1;
				res_init.key_out   = cell_key[in_data.cursor_in[IW-1:0]];
				res_init.child_out = child32(cell_child[in_data.cursor_in[IW-1:0]]);
			end
		end else if (in_data.cmd == CMD_INSERT && fill_q >= CW'(DEPTH)) begin
			res_init.status = ST_FULL;
		end
	end

	// scan-step decisions
	logic scan_done;
	logic shift_stop;
	always_comb begin
		ins_go     = 1'b0;
		ins_pos    = idx_q;
		sub_go     = 1'b0;
		shift_stop = 1'b0;
		scan_done  = !in_fill;
		if (state_q == S_SCAN) begin
			unique case (cmd_q.cmd)
				CMD_PROBE: begin
					scan_done = !in_fill || cur_key >= cmd_q.key_a;
				end
				CMD_INSERT: begin
					if (!in_fill || (idx_q == '0 && cur_key >= cmd_q.key_a) ||
					    cur_key > cmd_q.key_a) begin
						scan_done = 1'b1;
						ins_go    = 1'b1;
					end
				end
				CMD_SHIFT: begin
					if (in_fill && cur_key >= cmd_q.key_a) begin
						if ($signed(cur_key) < cmd_q.delta) begin
							shift_stop = 1'b1;
							scan_done  = 1'b1;
						end else begin
							sub_go = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	logic [CW-1:0] n_ext;
	assign n_ext = hi_q - lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (out_fire)
				res_v_q <= 1'b1;
			else if (out_ready)
				res_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q     <= in_data;
						idx_q     <= (in_data.cmd == CMD_PROBE) ? CW'(in_data.cursor_in) : '0;
						have_l_q  <= 1'b0;
						have_r_q  <= 1'b0;
						have_lo_q <= 1'b0;
						have_hi_q <= 1'b0;
						res_q     <= res_init;
						if (in_data.cmd == CMD_PROBE) begin
							if (7'(in_data.cursor_in) >= 7'(fill_q))
								state_q <= S_OUT;
							else
								state_q <= S_SCAN;
						end else if (in_data.cmd == CMD_READ) begin
							state_q <= S_OUT;
						end else if (in_data.cmd == CMD_INSERT) begin
							if (fill_q >= CW'(DEPTH))
								state_q <= S_OUT;
							else
								state_q <= S_SCAN;
						end else if (in_data.cmd == CMD_SHIFT ||
						             in_data.cmd == CMD_DELETE ||
						             in_data.cmd == CMD_EXTRACT) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					unique case (cmd_q.cmd)
						CMD_PROBE: if (scan_done) begin
							res_q.cursor_out <= 6'(idx_q);
							res_q.found <= in_fill && cur_key == cmd_q.key_a;
							state_q <= S_OUT;
						end
						CMD_INSERT: if (scan_done) begin
							fill_q  <= fill_q + 1'b1;
							state_q <= S_OUT;
						end
						CMD_SHIFT: if (scan_done) begin
							if (shift_stop) res_q.status <= ST_SMALL;
							state_q <= S_OUT;
						end
						CMD_DELETE: begin
							if (in_fill) begin
								if (!have_l_q && cur_key >= cmd_q.key_a) begin
									l_q <= idx_q;
									have_l_q <= 1'b1;
								end
								if (cur_key <= cmd_q.key_b) begin
									r_q <= idx_q;
									have_r_q <= 1'b1;
								end
							end else begin
								if (have_l_q && have_r_q && l_q <= r_q) begin
									lo_q <= l_q;
									mv_q <= r_q - l_q + 1'b1;
									state_q <= S_MOVE;
								end else begin
									state_q <= S_OUT;
								end
							end
						end
						default: begin
							if (in_fill) begin
								if (!have_lo_q && cur_key >= cmd_q.key_a) begin
									lo_q <= idx_q;
									have_lo_q <= 1'b1;
								end
								if (!have_hi_q && cur_key >= cmd_q.key_b) begin
									hi_q <= idx_q;
									have_hi_q <= 1'b1;
								end
							end else begin
								if (!have_lo_q) lo_q <= fill_q;
								if (!have_hi_q) hi_q <= fill_q;
								state_q <= S_EMIT;
							end
						end
					endcase
				end
				S_MOVE: begin
					fill_q <= fill_q - 1'b1;
					mv_q   <= mv_q - 1'b1;
					if (mv_q == CW'(1))
						state_q <= S_OUT;
				end
				S_EMIT: begin
					if (hi_q <= lo_q) begin
						state_q <= S_OUT;
					end else if (out_fire) begin
						res_q.has_entry   <= 1'b1;
						res_q.key_out     <= cell_key[lo_q[IW-1:0]];
						res_q.child_out   <= child32(cell_child[lo_q[IW-1:0]]);
						res_q.entry_count <= 6'(fill_q - n_ext);
						res_q.last        <= n_ext == CW'(1);
						fill_q <= fill_q - 1'b1;
						hi_q   <= hi_q - 1'b1;
						if (n_ext == CW'(1))
							state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_fire) begin
						res_q.entry_count <= 6'(fill_q);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE) && (!res_v_q || out_ready);
	assign out_valid = res_v_q;
	assign out_data  = res_q;

	property p_fill_bound;
		@(posedge clk) disable iff (!arst_n) fill_q <= CW'(DEPTH);
	endproperty
	a_fill_bound: assert property (p_fill_bound) else $error("fill over depth");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ready) else $error("ready while busy");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ins_go |=> fill_q == $past(fill_q) + 1'b1) else $error("insert count");

	a_move_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOVE |=> fill_q == $past(fill_q) - 1'b1) else $error("move count");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the sorted key table engine against a behavioral table model.
// Directed commands cover the edge cases, then random command streams.
// ----------------------------------------------------------------------------
import sktab_pkg::*;

class key_table_board;
	logic [31:0] keys[32];
	logic [31:0] kids[32];
	int          fill;
	out_word_t   pending[$];
	int          errors;
	int          words_seen;

	function new();
		fill = 0;
		errors = 0;
		words_seen = 0;
	endfunction

	function out_word_t mk(logic [1:0] st, logic fnd, logic [5:0] cur, logic has,
			logic [31:0] k, logic [31:0] c, logic lst);
		out_word_t w;
		w.status = st;
		w.found = fnd;
		w.cursor_out = cur;
		w.has_entry = has;
		w.key_out = k;
		w.child_out = c;
		w.entry_count = fill[5:0];
		w.last = lst;
		return w;
	endfunction

	function int lower_idx(logic [31:0] k);
		for (int i = 0; i < fill; i++)
			if (keys[i] >= k)
				return i;
		return fill;
	endfunction

	function void drop(int lo, int n);
		for (int i = lo; i + n < fill; i++) begin
			keys[i] = keys[i + n];
			kids[i] = kids[i + n];
		end
		fill -= n;
	endfunction

	function void note_input(in_word_t w);
		int c, p, l, r, lo, hi, n;
		bit hl, hr;
		logic [1:0] st;
		logic [31:0] xk[32];
		logic [31:0] xc[32];
		case (w.cmd)
		CMD_PROBE: begin
			c = w.cursor_in;
			hl = 0;
			if (c < fill) begin
				while (c < fill && keys[c] < w.key_a)
					c++;
				hl = (c < fill && keys[c] == w.key_a);
			end
			pending.push_back(mk(ST_OK, hl, c[5:0], 0, 0, 0, 1));
		end
		CMD_READ: begin
			if (w.cursor_in >= fill)
				pending.push_back(mk(ST_RANGE, 0, 0, 0, 0, 0, 1));
			else
				pending.push_back(mk(ST_OK, 0, 0, 1, keys[w.cursor_in],
					kids[w.cursor_in], 1));
		end
		CMD_INSERT: begin
			if (fill >= 32) begin
				pending.push_back(mk(ST_FULL, 0, 0, 0, 0, 0, 1));
			end else begin
				p = 0;
				if (fill != 0 && keys[0] < w.key_a) begin
					p = fill;
					for (int i = 0; i < fill; i++)
						if (keys[i] > w.key_a) begin
							p = i;
							break;
						end
				end
				for (int i = fill; i > p; i--) begin
					keys[i] = keys[i - 1];
					kids[i] = kids[i - 1];
				end
				keys[p] = w.key_a;
				kids[p] = w.child_in;
				fill++;
				pending.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 1));
			end
		end
		CMD_SHIFT: begin
			st = ST_OK;
			for (int i = 0; i < fill; i++)
				if (keys[i] >= w.key_a) begin
					if ($signed(keys[i]) < w.delta) begin
						st = ST_SMALL;
						break;
					end
					keys[i] = keys[i] - w.delta;
				end
			pending.push_back(mk(st, 0, 0, 0, 0, 0, 1));
		end
		CMD_DELETE: begin
			hl = 0;
			hr = 0;
			l = 0;
			r = 0;
			for (int i = 0; i < fill; i++) begin
				if (!hl && keys[i] >= w.key_a) begin
					l = i;
					hl = 1;
				end
				if (keys[i] <= w.key_b) begin
					r = i;
					hr = 1;
				end
			end
			if (hl && hr && l <= r)
				drop(l, r - l + 1);
			pending.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 1));
		end
		CMD_EXTRACT: begin
			lo = lower_idx(w.key_a);
			hi = lower_idx(w.key_b);
			if (hi <= lo) begin
				pending.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 1));
			end else begin
				n = hi - lo;
				for (int i = 0; i < n; i++) begin
					xk[i] = keys[lo + i];
					xc[i] = kids[lo + i];
				end
				drop(lo, n);
				for (int i = 0; i < n; i++)
					pending.push_back(mk(ST_OK, 0, 0, 1, xk[i], xc[i], i + 1 == n));
			end
		end
		default: pending.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 1));
		endcase
	endfunction

	function void check_word(out_word_t a);
		out_word_t e;
		words_seen++;
		if (pending.size() == 0) begin
			$error("unexpected word %h", a);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (a.status !== e.status) begin
			$error("status exp %0d got %0d", e.status, a.status);
			errors++;
		end
		if (a.found !== e.found) begin
			$error("found exp %0d got %0d", e.found, a.found);
			errors++;
		end
		if (a.cursor_out !== e.cursor_out) begin
			$error("cursor_out exp %0d got %0d", e.cursor_out, a.cursor_out);
			errors++;
		end
		if (a.has_entry !== e.has_entry) begin
			$error("has_entry exp %0d got %0d", e.has_entry, a.has_entry);
			errors++;
		end
		if (a.key_out !== e.key_out) begin
			$error("key_out exp %h got %h", e.key_out, a.key_out);
			errors++;
		end
		if (a.child_out !== e.child_out) begin
			$error("child_out exp %h got %h", e.child_out, a.child_out);
			errors++;
		end
		if (a.entry_count !== e.entry_count) begin
			$error("entry_count exp %0d got %0d", e.entry_count, a.entry_count);
			errors++;
		end
		if (a.last !== e.last) begin
			$error("last exp %0d got %0d", e.last, a.last);
			errors++;
		end
	endfunction
endclass

module tb;
	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 0;
	out_word_t out_data;

	key_table_board board = new();
	bit        calm = 0;
	int        cycle = 0;
	int        sent = 0;

	sorted_key_table_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 400000) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_input(in_data);
			if (out_valid && out_ready)
				board.check_word(out_data);
			out_ready <= calm || ($urandom_range(99) >= 35);
		end
	end

	task automatic send_word(in_word_t w);
		while (!calm && $urandom_range(99) < 35) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_cmd(logic [2:0] c, logic [31:0] ka, logic [31:0] kb,
			logic [5:0] cur, logic [31:0] ch, logic [31:0] d);
		in_word_t w;
		w.cmd = c;
		w.key_a = ka;
		w.key_b = kb;
		w.cursor_in = cur;
		w.child_in = ch;
		w.delta = d;
		send_word(w);
	endtask

	function automatic logic [31:0] rkey();
		case ($urandom_range(3))
		0: return $urandom_range(40);
		1: return 32'hFFFFFFFF - $urandom_range(40);
		2: return 32'h80000000 + $urandom_range(20) - 10;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rdelta();
		case ($urandom_range(3))
		0: return $urandom_range(10);
		1: return -$urandom_range(10);
		2: return $urandom;
		default: return 32'h80000000;
		endcase
	endfunction

	task automatic random_cmd();
		logic [2:0] c;
		c = 3'($urandom_range(7));
		if (c > CMD_EXTRACT && $urandom_range(3) != 0)
			c = CMD_INSERT;
		if ($urandom_range(2) == 0)
			c = CMD_INSERT;
		send_cmd(c, rkey(), rkey(), 6'($urandom_range(33)), $urandom, rdelta());
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		calm = 1;
		send_cmd(CMD_PROBE, 5, 0, 0, 0, 0);
		send_cmd(CMD_READ, 0, 0, 0, 0, 0);
		send_cmd(CMD_EXTRACT, 0, 32'hFFFFFFFF, 0, 0, 0);
		send_cmd(CMD_DELETE, 0, 32'hFFFFFFFF, 0, 0, 0);
		for (int i = 0; i < 33; i++)
			send_cmd(CMD_INSERT, (i * 7) % 33 + (i == 5 ? 32'hFFFFFFF0 : 0),
				0, 0, 32'hA5000000 ^ i, 0);
		calm = 0;
		send_cmd(CMD_INSERT, 3, 0, 0, 1, 0);
		send_cmd(CMD_PROBE, 10, 0, 0, 0, 0);
		send_cmd(CMD_PROBE, 32'hFFFFFFFF, 0, 2, 0, 0);
		send_cmd(CMD_PROBE, 0, 0, 32, 0, 0);
		send_cmd(CMD_READ, 0, 0, 31, 0, 0);
		send_cmd(CMD_READ, 0, 0, 32, 0, 0);
		send_cmd(CMD_READ, 0, 0, 63, 0, 0);
		send_cmd(CMD_SHIFT, 20, 0, 0, 0, 32'hFFFFFFFE);
		send_cmd(CMD_SHIFT, 0, 0, 0, 0, 32'h7FFFFFFF);
		send_cmd(CMD_DELETE, 20, 10, 0, 0, 0);
		send_cmd(CMD_DELETE, 4, 8, 0, 0, 0);
		send_cmd(CMD_EXTRACT, 15, 10, 0, 0, 0);
		send_cmd(CMD_EXTRACT, 10, 15, 0, 0, 0);
		send_cmd(3'd6, 0, 0, 0, 0, 0);
		send_cmd(3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 63, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_cmd(CMD_EXTRACT, 0, 32'hFFFFFFFF, 0, 0, 0);
		send_cmd(CMD_INSERT, 32'hFFFFFFFF, 0, 0, 32'hFFFFFFFF, 0);
		send_cmd(CMD_EXTRACT, 0, 32'hFFFFFFFF, 0, 0, 0);
		for (int i = 0; i < 75; i++) begin
			calm = (i >= 20 && i < 50);
			random_cmd();
		end
		in_valid <= 0;
		calm = 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("Ran %0d commands, %0d result words checked, covering every command.",
			sent, board.words_seen);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

/* sorted_key_table_engine_top.f */
hw/rtl/sktab_pkg.sv
hw/rtl/sktab_cell.sv
hw/rtl/sorted_key_table_engine_top.sv
test/tb.sv
